### rtl/bcmp_pkg.sv
// Shared constants, codes and types for the binomial coefficient modulo prime core
package bcmp_pkg;

    localparam int unsigned WordW = 63;
    localparam int unsigned NW = 11;
    localparam int unsigned KW = 12;
    localparam int unsigned MaxNDefault = 1024;
    localparam logic [WordW-1:0] ModReset = 63'd1000000007;

    localparam logic [1:0] KIND_BUILD = 2'd0;
    localparam logic [1:0] KIND_BINOM = 2'd1;
    localparam logic [1:0] KIND_PERM = 2'd2;
    localparam logic [1:0] KIND_FACT = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_UNBUILT = 2'd2;

    localparam logic CFG_MODULUS = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    typedef struct packed {
        logic start;
        logic [WordW-1:0] a;
        logic [WordW-1:0] b;
    } t_mul_req;

endpackage

### rtl/bcmp_mulmod.sv
// Shift-add-subtract modular multiplier, one bit of the multiplier a cycle once both operands are below the modulus
module bcmp_mulmod (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bcmp_pkg::t_mul_req              i_req,
    input  logic [bcmp_pkg::WordW-1:0]      i_mod,
    output logic                            o_done,
    output logic [bcmp_pkg::WordW-1:0]      o_prod
);
    localparam int unsigned W = bcmp_pkg::WordW;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_RA = 3'd1;
    localparam logic [2:0] PH_DA = 3'd2;
    localparam logic [2:0] PH_RB = 3'd3;
    localparam logic [2:0] PH_DB = 3'd4;
    localparam logic [2:0] PH_RUN = 3'd5;

    logic [W-1:0] r_a, n_a, r_b, n_b, r_acc, n_acc;
    logic [2:0] r_ph, n_ph;
    logic [5:0] r_bit, n_bit;
    logic r_done, n_done;
    logic feed;
    logic [W:0] dbl, dbl_r, add, add_r;
    logic [W-1:0] dbl_m;

    always_comb begin
        case (r_ph)
            PH_DA: feed = r_a[r_bit];
            PH_DB: feed = r_b[r_bit];
            default: feed = 1'b0;
        endcase
        dbl = {r_acc, feed};
        dbl_r = (dbl >= {1'b0, i_mod}) ? dbl - {1'b0, i_mod} : dbl;
        dbl_m = dbl_r[W-1:0];
        add = {1'b0, dbl_m} + {1'b0, r_a};
        add_r = (add >= {1'b0, i_mod}) ? add - {1'b0, i_mod} : add;
    end

    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_acc = r_acc;
        n_ph = r_ph;
        n_bit = r_bit;
        n_done = 1'b0;
        case (r_ph)
            PH_IDLE: begin
                if (i_req.start) begin
                    n_a = i_req.a;
                    n_b = i_req.b;
                    n_ph = PH_RA;
                end
            end
            PH_RA: begin
                n_acc = '0;
                n_bit = 6'(W - 1);
                n_ph = (r_a >= i_mod) ? PH_DA : PH_RB;
            end
            PH_DA: begin
                n_acc = dbl_m;
                n_bit = r_bit - 6'd1;
                if (r_bit == 6'd0) begin
                    n_a = dbl_m;
                    n_ph = PH_RB;
                end
            end
            PH_RB: begin
                n_acc = '0;
                n_bit = 6'(W - 1);
                n_ph = (r_b >= i_mod) ? PH_DB : PH_RUN;
            end
            PH_DB: begin
                n_acc = dbl_m;
                n_bit = r_bit - 6'd1;
                if (r_bit == 6'd0) begin
                    n_b = dbl_m;
                    n_acc = '0;
                    n_bit = 6'(W - 1);
                    n_ph = PH_RUN;
                end
            end
            PH_RUN: begin
                n_acc = r_b[r_bit] ? add_r[W-1:0] : dbl_m;
                n_bit = r_bit - 6'd1;
                if (r_bit == 6'd0) begin
                    n_ph = PH_IDLE;
                    n_done = 1'b1;
                end
            end
            default: n_ph = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_IDLE;
            r_done <= 1'b0;
        end else begin
            r_ph <= n_ph;
            r_done <= n_done;
        end
        r_a <= n_a;
        r_b <= n_b;
        r_acc <= n_acc;
        r_bit <= n_bit;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

### rtl/binomial_coefficient_mod_prime_core.sv
// Top level: sequencer, factorial tables and configuration registers
// A binomial query makes two passes of the shared shift-add modular multiplier, with a
// table read before the first pass, a table reload before the second and a result state
// after; a permutation or factorial query makes one pass, and an error or empty result none.
// Each operand not below the modulus, as after a modulus change over built tables, adds a
// reduction pass in the multiplier. A build runs two table sweeps and the square-and-multiply
// inversion by the power modulus-2, all on the one multiplier. Results appear on o_valid
// for one cycle and cannot be stalled; busy is high from start through the result cycle.
module binomial_coefficient_mod_prime_core #(
    parameter int unsigned MAX_N = bcmp_pkg::MaxNDefault
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [bcmp_pkg::WordW-1:0]      i_cfg_data,
    input  logic [1:0]                      i_kind,
    input  logic [bcmp_pkg::NW-1:0]         i_top,
    input  logic signed [bcmp_pkg::KW-1:0]  i_choose,
    output logic                            o_valid,
    output logic [bcmp_pkg::WordW-1:0]      o_value,
    output logic [1:0]                      o_status
);
    localparam int unsigned W = bcmp_pkg::WordW;
    localparam int unsigned NW = bcmp_pkg::NW;
    localparam int unsigned AW = $clog2(MAX_N + 1);
    localparam logic [NW-1:0] MaxNV = NW'(MAX_N);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD = 4'd1;
    localparam logic [3:0] S_Q1 = 4'd2;
    localparam logic [3:0] S_Q2 = 4'd3;
    localparam logic [3:0] S_OUT = 4'd4;
    localparam logic [3:0] S_F = 4'd5;
    localparam logic [3:0] S_PW = 4'd6;
    localparam logic [3:0] S_PWS = 4'd7;
    localparam logic [3:0] S_INV = 4'd8;
    localparam logic [3:0] S_Q2R = 4'd10;

    logic [W-1:0] fact_mem [0:MAX_N];
    logic [W-1:0] ifact_mem [0:MAX_N];

    logic [W-1:0] r_mod;
    logic [NW-1:0] r_lim_cfg;
    logic [NW-1:0] r_built, n_built;
    logic r_valid_tab, n_valid_tab;
    logic [3:0] r_st, n_st;
    logic [1:0] r_kind, n_kind;
    logic [NW-1:0] r_n, n_n, r_k, n_k, r_i, n_i;
    logic [W-1:0] r_x, n_x, r_base, n_base, r_exp, n_exp;
    logic r_ostb, n_ostb;
    logic [W-1:0] r_oval, n_oval;
    logic [1:0] r_ostat, n_ostat;
    logic r_go, n_go;
    logic r_sq, n_sq;
    logic [W-1:0] r_fa, r_fb, r_ib;
    logic [AW-1:0] n_ra, n_rb;
    logic n_fwe, n_iwe;
    logic [AW-1:0] n_wa;
    logic [W-1:0] n_wd;
    logic [W-1:0] mul_a, mul_b;
    bcmp_pkg::t_mul_req mreq;
    logic mdone;
    logic [W-1:0] mprod;
    logic [W-1:0] effm;
    logic [NW-1:0] lim_sat;

    assign effm = (r_mod == '0) ? W'(1) : r_mod;
    assign lim_sat = (r_lim_cfg > MaxNV) ? MaxNV : r_lim_cfg;

    assign mreq.start = r_go;
    assign mreq.a = mul_a;
    assign mreq.b = mul_b;

    bcmp_mulmod u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mreq), .i_mod(effm),
        .o_done(mdone), .o_prod(mprod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= bcmp_pkg::ModReset;
            r_lim_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bcmp_pkg::CFG_MODULUS: r_mod <= i_cfg_data;
                bcmp_pkg::CFG_LIMIT: r_lim_cfg <= i_cfg_data[NW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_fwe) fact_mem[n_wa] <= n_wd;
        if (n_iwe) ifact_mem[n_wa] <= n_wd;
        r_fa <= fact_mem[n_ra];
        r_fb <= ifact_mem[n_rb];
        r_ib <= ifact_mem[n_ra];
    end

    always_comb begin
        n_st = r_st;
        n_kind = r_kind;
        n_n = r_n;
        n_k = r_k;
        n_i = r_i;
        n_x = r_x;
        n_base = r_base;
        n_exp = r_exp;
        n_built = r_built;
        n_valid_tab = r_valid_tab;
        n_ostb = 1'b0;
        n_oval = r_oval;
        n_ostat = r_ostat;
        n_go = 1'b0;
        n_sq = r_sq;
        n_ra = r_n[AW-1:0];
        n_rb = AW'(r_n - r_k);
        n_fwe = 1'b0;
        n_iwe = 1'b0;
        n_wa = r_i[AW-1:0];
        n_wd = mprod;
        mul_a = r_x;
        mul_b = {{(W-NW){1'b0}}, r_i};
        case (r_st)
            S_IDLE: begin
                if (start && !busy) begin
                    n_kind = i_kind;
                    n_n = i_top;
                    n_k = i_choose[NW-1:0];
                    if (i_kind == bcmp_pkg::KIND_BUILD) begin
                        n_fwe = 1'b1;
                        n_wa = '0;
                        n_wd = (effm == W'(1)) ? '0 : W'(1);
                        n_x = n_wd;
                        n_i = NW'(1);
                        n_built = lim_sat;
                        n_st = S_F;
                        n_go = (lim_sat != '0);
                    end else begin
                        n_oval = '0;
                        n_ostat = bcmp_pkg::ST_OK;
                        if (!r_valid_tab) begin
                            n_ostat = bcmp_pkg::ST_UNBUILT;
                            n_st = S_OUT;
                        end else if (i_top > r_built) begin
                            n_ostat = bcmp_pkg::ST_RANGE;
                            n_st = S_OUT;
                        end else if (i_kind != bcmp_pkg::KIND_FACT &&
                                     (i_choose[bcmp_pkg::KW-1] ||
                                      i_choose[NW-1:0] > i_top)) begin
                            n_st = S_OUT;
                        end else begin
                            n_st = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                n_st = S_Q1;
                n_go = 1'b1;
            end
            S_Q1: begin
                mul_a = r_fa;
                mul_b = (r_kind == bcmp_pkg::KIND_FACT) ? W'(1) : r_fb;
                n_k = r_k;
                if (mdone) begin
                    n_oval = mprod;
                    if (r_kind == bcmp_pkg::KIND_BINOM) begin
                        n_ra = r_k[AW-1:0];
                        n_st = S_Q2R;
                    end else begin
                        n_st = S_OUT;
                    end
                end
            end
            S_Q2R: begin
                n_ra = r_k[AW-1:0];
                n_st = S_Q2;
                n_go = 1'b1;
            end
            S_Q2: begin
                mul_a = r_oval;
                mul_b = r_ib;
                if (mdone) begin
                    n_oval = mprod;
                    n_st = S_OUT;
                end
            end
            S_OUT: begin
                n_ostb = 1'b1;
                n_st = S_IDLE;
            end
            S_F: begin
                if (r_i > r_built) begin
                    n_base = r_x;
                    n_exp = (effm >= W'(2)) ? effm - W'(2) : '0;
                    n_x = (effm == W'(1)) ? '0 : W'(1);
                    n_sq = 1'b0;
                    n_st = S_PW;
                    n_go = (effm > W'(2));
                end else if (mdone) begin
                    n_fwe = 1'b1;
                    n_x = mprod;
                    n_i = r_i + NW'(1);
                    n_go = (r_i != r_built);
                    if (r_i == r_built) n_oval = mprod;
                    if (r_i == r_built) n_i = r_i + NW'(1);
                end
                if (r_built == '0 && r_i == NW'(1)) n_oval = r_x;
            end
            S_PW: begin
                mul_a = r_sq ? r_base : r_x;
                mul_b = r_base;
                if (r_exp == '0) begin
                    n_iwe = 1'b1;
                    n_wa = r_built[AW-1:0];
                    n_wd = r_x;
                    n_i = r_built;
                    n_st = S_INV;
                    n_go = (r_built != '0);
                end else if (mdone) begin
                    if (!r_sq) begin
                        if (r_exp[0]) n_x = mprod;
                        n_sq = 1'b1;
                        n_go = 1'b1;
                    end else begin
                        n_base = mprod;
                        n_exp = r_exp >> 1;
                        n_sq = 1'b0;
                        n_go = (r_exp[W-1:1] != '0);
                    end
                end
                if (r_exp == '0) n_x = r_x;
            end
            S_INV: begin
                mul_a = r_x;
                mul_b = {{(W-NW){1'b0}}, r_i};
                if (r_i == '0) begin
                    n_valid_tab = 1'b1;
                    n_ostat = bcmp_pkg::ST_OK;
                    n_st = S_OUT;
                end else if (mdone) begin
                    n_iwe = 1'b1;
                    n_wa = AW'(r_i - NW'(1));
                    n_x = mprod;
                    n_i = r_i - NW'(1);
                    n_go = (r_i != NW'(1));
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_valid_tab <= 1'b0;
            r_built <= '0;
            r_ostb <= 1'b0;
            r_go <= 1'b0;
        end else begin
            r_st <= n_st;
            r_valid_tab <= n_valid_tab;
            r_built <= n_built;
            r_ostb <= n_ostb;
            r_go <= n_go;
        end
        r_kind <= n_kind;
        r_n <= n_n;
        r_k <= n_k;
        r_i <= n_i;
        r_x <= n_x;
        r_base <= n_base;
        r_exp <= n_exp;
        r_sq <= n_sq;
        r_oval <= n_oval;
        r_ostat <= n_ostat;
    end

    assign busy = (r_st != S_IDLE) || r_ostb;
    assign o_valid = r_ostb;
    assign o_value = r_oval;
    assign o_status = r_ostat;

`ifndef SYNTHESIS
    a_out_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result while idle");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != bcmp_pkg::ST_OK |-> o_value == '0)
        else $error("error result carries a value");
`endif
endmodule
